[sv/counting_semaphore_table_unit_defines.svh]
// Assertion macros for the semaphore table unit.
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cst_pkg.sv]
// Shared types and constants of the semaphore table unit.
package cst_pkg;

	localparam int CST_OP_W      = 2;
	localparam int CST_ID_W      = 16;
	localparam int CST_CNT_W     = 16;
	localparam int CST_STATUS_W  = 2;

	localparam int CST_TABLE_ENTRIES = 16;
	localparam int CST_ID_BITS       = 16;
	localparam int CST_COUNT_BITS    = 16;

	// candidate bits examined per scan cycle
	localparam int CST_SCAN_LANES = 8;

	typedef enum logic [CST_OP_W-1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_WAIT    = 2'd2,
		OP_SIGNAL  = 2'd3
	} cst_op_t;

	typedef enum logic [CST_STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} cst_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_COMMIT
	} cst_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cst_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
		logic out_free;
	} cst_stat_t;

endpackage

[sv/cst_intf.sv]
// Request and response channel interfaces of the semaphore table unit.
interface cst_req_if import cst_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [CST_OP_W-1:0]         op;
	logic [CST_ID_W-1:0]         sem_id;
	logic signed [CST_CNT_W-1:0] init_value;

	modport source (output valid, output op, output sem_id, output init_value, input ready);
	modport sink   (input valid, input op, input sem_id, input init_value, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [CST_STATUS_W-1:0]     status;
	logic [CST_ID_W-1:0]         new_id;
	logic                        must_block;
	logic                        wake_one;
	logic signed [CST_CNT_W-1:0] count_after;

	modport source (output valid, output status, output new_id, output must_block,
		output wake_one, output count_after, input ready);
	modport sink   (input valid, input status, input new_id, input must_block,
		input wake_one, input count_after, output ready);
endinterface

[sv/counting_semaphore_table_unit.sv]
// Top level of the counting semaphore table unit.
// A table of TABLE_ENTRIES counting semaphores that serves one request at a
// time: create (op 0) takes the lowest free slot, clamps init_value to the
// COUNT_BITS signed range and tags the slot with the next id of a wrapping
// ID_BITS counter; destroy (op 1) frees the lowest slot whose tag matches
// sem_id; wait (op 2) decrements with saturation and raises must_block when
// the count ends below zero; signal (op 3) increments with saturation and
// raises wake_one when the count ends at or below zero. status reports ok,
// id not found, or table full on create. A request steps through an accept
// state that also compares every tag against sem_id, the eight-wide
// priority scan over the match vector, group by group up to the first group
// with a matching slot, the count memory read, and a commit state. A failed
// search skips the memory read. The result sits in an output register, so a
// new request is taken while the previous result still waits on rsp.ready;
// commit stalls only while that register is occupied and rsp.ready is low.
// Valid bits live in flip-flops cleared by reset, so no clearing pass runs.
`include "counting_semaphore_table_unit_defines.svh"

module counting_semaphore_table_unit import cst_pkg::*; #(
	parameter int TABLE_ENTRIES = CST_TABLE_ENTRIES,
	parameter int ID_BITS       = CST_ID_BITS,
	parameter int COUNT_BITS    = CST_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cst_req_if.sink   req,
	cst_rsp_if.source rsp
);

	cst_cmd_t  cmd;
	cst_stat_t st;

	// sequencer
	cst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// tag compare, slot scan, count update, result register
	cst_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ID_BITS       (ID_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.req_op         (req.op),
		.req_sem_id     (req.sem_id),
		.req_init_value (req.init_value),
		.rsp            (rsp)
	);

	// one request in flight: no second request right after acceptance
	`CST_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted twice in a row")
	// a commit always lands in the result register
	`CST_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp.valid, "commit left no result")
	// idle sequencer drives no scan or commit
	`CST_ASSERT_SAME(a_idle_quiet, req.ready, !cmd.scan && !cmd.commit, "datapath busy while idle")

endmodule

[sv/cst_ctrl.sv]
// Request sequencer: accept, scan, count read, commit.
module cst_ctrl import cst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  cst_stat_t st,
	output cst_cmd_t  cmd
);

	cst_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (st.hit) state_d = S_READ;
				else if (st.last) state_d = S_COMMIT;
			end
			S_READ: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (st.out_free) state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_READ: begin
			end
			S_COMMIT: begin
				cmd.commit = st.out_free;
			end
		endcase
	end

endmodule

[sv/cst_dp.sv]
// Semaphore table datapath: tags, valid bits, count memory, result register.
module cst_dp import cst_pkg::*; #(
	parameter int TABLE_ENTRIES = CST_TABLE_ENTRIES,
	parameter int ID_BITS       = CST_ID_BITS,
	parameter int COUNT_BITS    = CST_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cst_cmd_t                    cmd,
	output cst_stat_t                   st,
	input  logic [CST_OP_W-1:0]         req_op,
	input  logic [CST_ID_W-1:0]         req_sem_id,
	input  logic signed [CST_CNT_W-1:0] req_init_value,
	cst_rsp_if.source                   rsp
);

	localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
	localparam int NGROUPS   = (TABLE_ENTRIES + CST_SCAN_LANES - 1) / CST_SCAN_LANES;
	localparam int GI_BITS   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam int LANE_BITS = $clog2(CST_SCAN_LANES);
	localparam int PAD       = NGROUPS * CST_SCAN_LANES;
	localparam int EXT_W     = 33;
	localparam logic [GI_BITS-1:0] GI_LAST = GI_BITS'(NGROUPS - 1);

	localparam logic signed [COUNT_BITS-1:0] MAXC = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] MINC = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic signed [COUNT_BITS-1:0] ONEC = {{(COUNT_BITS-1){1'b0}}, 1'b1};
	localparam logic signed [EXT_W-1:0] MAX_EXT = {{(EXT_W-COUNT_BITS){1'b0}}, MAXC};
	localparam logic signed [EXT_W-1:0] MIN_EXT = {{(EXT_W-COUNT_BITS){1'b1}}, MINC};

	// table state
	logic [TABLE_ENTRIES-1:0]       valid_q;
	logic [ID_BITS-1:0]             tag_q [TABLE_ENTRIES];
	logic signed [COUNT_BITS-1:0]   cnt_mem [TABLE_ENTRIES];
	logic signed [COUNT_BITS-1:0]   rd_q;
	logic [ID_BITS-1:0]             next_id_q;

	// request registers
	cst_op_t                        op_q;
	logic signed [CST_CNT_W-1:0]    init_q;
	logic [PAD-1:0]                 cand_q;
	logic [GI_BITS-1:0]             gi_q;
	logic [SLOT_BITS-1:0]           slot_q;
	logic                           found_q;

	// result register
	logic                           out_valid_q;
	cst_status_t                    status_q;
	logic [CST_ID_W-1:0]            new_id_q;
	logic                           blk_q;
	logic                           wake_q;
	logic signed [CST_CNT_W-1:0]    cnt_out_q;

	function automatic logic [CST_CNT_W-1:0] cnt_to_port(logic signed [COUNT_BITS-1:0] c);
		logic [EXT_W-1:0] ext;
		ext = {{(EXT_W-COUNT_BITS){c[COUNT_BITS-1]}}, c};
		return ext[CST_CNT_W-1:0];
	endfunction

	// ---- candidate vector at accept ----
	logic [EXT_W-1:0]   id_ext;
	logic [ID_BITS-1:0] id_cmp;
	logic [PAD-1:0]     cand_d;

	assign id_ext = {{(EXT_W-CST_ID_W){1'b0}}, req_sem_id};
	assign id_cmp = id_ext[ID_BITS-1:0];

	always_comb begin
		cand_d = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (cst_op_t'(req_op) == OP_CREATE) cand_d[i] = !valid_q[i];
			else cand_d[i] = valid_q[i] && (tag_q[i] == id_cmp);
		end
	end

	// ---- group scan, lowest index first ----
	logic [CST_SCAN_LANES-1:0] grp;
	logic [LANE_BITS-1:0]      off;
	logic [GI_BITS+LANE_BITS-1:0] slot_wide;

	assign grp       = cand_q[{gi_q, {LANE_BITS{1'b0}}} +: CST_SCAN_LANES];
	assign slot_wide = {gi_q, off};

	always_comb begin
		off = '0;
		for (int i = CST_SCAN_LANES - 1; i >= 0; i--) begin
			if (grp[i]) off = LANE_BITS'(i);
		end
	end

	assign st.hit      = cmd.scan && (|grp);
	assign st.last     = (gi_q == GI_LAST);
	assign st.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= cst_op_t'(req_op);
			init_q  <= req_init_value;
			cand_q  <= cand_d;
			gi_q    <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (|grp) begin
				slot_q  <= slot_wide[SLOT_BITS-1:0];
				found_q <= 1'b1;
			end else if (!st.last) begin
				gi_q <= gi_q + GI_BITS'(1);
			end
		end
	end

	// ---- commit arithmetic ----
	logic signed [EXT_W-1:0]      init_ext;
	logic signed [COUNT_BITS-1:0] init_clamp;
	logic signed [COUNT_BITS-1:0] dec_c, inc_c, res_c;
	logic                         wr_en, set_v, clr_v, blk_d, wake_d;
	cst_status_t                  status_d;
	logic [CST_ID_W-1:0]          new_id_d;
	logic [EXT_W-1:0]             tag_ext;

	assign init_ext = {{(EXT_W-CST_CNT_W){init_q[CST_CNT_W-1]}}, init_q};
	assign tag_ext  = {{(EXT_W-ID_BITS){1'b0}}, next_id_q};

	always_comb begin
		if (init_ext > MAX_EXT) init_clamp = MAXC;
		else if (init_ext < MIN_EXT) init_clamp = MINC;
		else init_clamp = init_ext[COUNT_BITS-1:0];
		dec_c = (rd_q == MINC) ? MINC : rd_q - ONEC;
		inc_c = (rd_q == MAXC) ? MAXC : rd_q + ONEC;
	end

	always_comb begin
		status_d = STAT_OK;
		new_id_d = '0;
		res_c    = '0;
		blk_d    = 1'b0;
		wake_d   = 1'b0;
		wr_en    = 1'b0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		unique case (op_q)
			OP_CREATE: begin
				if (found_q) begin
					new_id_d = tag_ext[CST_ID_W-1:0];
					res_c    = init_clamp;
					wr_en    = 1'b1;
					set_v    = 1'b1;
				end else begin
					status_d = STAT_FULL;
				end
			end
			OP_DESTROY: begin
				if (found_q) begin
					res_c = rd_q;
					clr_v = 1'b1;
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
			OP_WAIT: begin
				if (found_q) begin
					res_c = dec_c;
					blk_d = dec_c[COUNT_BITS-1];
					wr_en = 1'b1;
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
			OP_SIGNAL: begin
				if (found_q) begin
					res_c  = inc_c;
					wake_d = inc_c[COUNT_BITS-1] || (inc_c == '0);
					wr_en  = 1'b1;
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
		endcase
	end

	// count memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		rd_q <= cnt_mem[slot_q];
		if (cmd.commit && wr_en) cnt_mem[slot_q] <= res_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && set_v) tag_q[slot_q] <= next_id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			next_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (set_v) begin
					valid_q[slot_q] <= 1'b1;
					next_id_q       <= next_id_q + ID_BITS'(1);
				end
				if (clr_v) valid_q[slot_q] <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= status_d;
			new_id_q  <= new_id_d;
			blk_q     <= blk_d;
			wake_q    <= wake_d;
			cnt_out_q <= cnt_to_port(res_c);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.new_id      = new_id_q;
	assign rsp.must_block  = blk_q;
	assign rsp.wake_one    = wake_q;
	assign rsp.count_after = cnt_out_q;

endmodule

[test/counting_semaphore_table_unit_tb.sv]
// Self-checking testbench of the counting semaphore table unit.
module counting_semaphore_table_unit_tb;
	import cst_pkg::*;

	localparam int ENTRIES = CST_TABLE_ENTRIES;
	// cycles with no handshake on either channel before the run is abandoned
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_REQUESTS = 900;
	localparam logic signed [CST_CNT_W-1:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [CST_CNT_W-1:0] COUNT_MIN = 16'sh8000;

	// One response as it appears on the response channel.
	typedef struct packed {
		cst_status_t                 status;
		logic [CST_ID_W-1:0]         new_id;
		logic                        must_block;
		logic                        wake_one;
		logic signed [CST_CNT_W-1:0] count_after;
	} sem_reply_t;

	// Mirror of the semaphore table plus the queue of responses still owed.
	// note_request updates the mirror when a request is accepted and queues
	// the response that request must produce; check_reply pops and compares.
	class sem_table_tracker;
		bit                          live[ENTRIES];
		logic [CST_ID_W-1:0]         tag[ENTRIES];
		logic signed [CST_CNT_W-1:0] count[ENTRIES];
		logic [CST_ID_W-1:0]         next_tag;
		sem_reply_t                  expected_replies[$];
		int                          mismatches;

		function new();
			next_tag = '0;
			mismatches = 0;
			foreach (live[i]) begin
				live[i] = 1'b0;
				tag[i] = '0;
				count[i] = '0;
			end
		endfunction

		function int live_count();
			int n;
			n = 0;
			foreach (live[i]) if (live[i]) n++;
			return n;
		endfunction

		// Lowest-numbered slot carrying this tag, -1 if none.
		function int slot_of(logic [CST_ID_W-1:0] id);
			foreach (live[i]) if (live[i] && tag[i] == id) return i;
			return -1;
		endfunction

		function logic [CST_ID_W-1:0] any_live_tag();
			int picks[$];
			foreach (live[i]) if (live[i]) picks.push_back(i);
			return tag[picks[$urandom_range(0, picks.size() - 1)]];
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void note_request(cst_op_t op, logic [CST_ID_W-1:0] id,
				logic signed [CST_CNT_W-1:0] init);
			sem_reply_t r;
			int s;
			r.status = STAT_OK;
			r.new_id = '0;
			r.must_block = 1'b0;
			r.wake_one = 1'b0;
			r.count_after = '0;
			s = -1;
			if (op == OP_CREATE) begin
				foreach (live[i]) if (!live[i] && s < 0) s = i;
				if (s < 0) begin
					r.status = STAT_FULL;
				end else begin
					// init is already within the 16-bit count range
					live[s] = 1'b1;
					tag[s] = next_tag;
					count[s] = init;
					r.new_id = next_tag;
					r.count_after = init;
					next_tag = next_tag + 1'b1;
				end
			end else begin
				s = slot_of(id);
				if (s < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					case (op)
						OP_DESTROY: begin
							r.count_after = count[s];
							live[s] = 1'b0;
						end
						OP_WAIT: begin
							if (count[s] != COUNT_MIN) count[s] = count[s] - 1'b1;
							r.count_after = count[s];
							r.must_block = (count[s] < 0);
						end
						default: begin
							if (count[s] != COUNT_MAX) count[s] = count[s] + 1'b1;
							r.count_after = count[s];
							r.wake_one = (count[s] <= 0);
						end
					endcase
				end
			end
			expected_replies.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_reply(sem_reply_t got);
			sem_reply_t want;
			if (expected_replies.size() == 0) begin
				mismatches++;
				$display("%0t: response with no request outstanding, expected none, actual %p",
					$time, got);
				return;
			end
			want = expected_replies.pop_front();
			compare_field("status", int'(want.status), int'(got.status));
			compare_field("new_id", int'(want.new_id), int'(got.new_id));
			compare_field("must_block", int'(want.must_block), int'(got.must_block));
			compare_field("wake_one", int'(want.wake_one), int'(got.wake_one));
			compare_field("count_after", int'($signed(want.count_after)),
				int'($signed(got.count_after)));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	// when set, neither side inserts gaps or stalls
	bit   quiet = 1'b0;
	int   idle_cycles = 0;

	sem_table_tracker sem_table = new();

	cst_req_if req_ch ();
	cst_rsp_if rsp_ch ();

	counting_semaphore_table_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length in cycles: mostly none, often a few, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Initial counts lean toward the saturation limits and toward zero, where
	// the block and wake flags flip; the rest spread over the whole range.
	function automatic logic signed [CST_CNT_W-1:0] random_init();
		int roll;
		int near_zero;
		roll = $urandom_range(0, 9);
		near_zero = $urandom_range(0, 6);
		case (roll)
			0: return COUNT_MIN;
			1: return COUNT_MAX;
			2: return COUNT_MAX - 16'sd1;
			3: return COUNT_MIN + 16'sd1;
			4, 5: return 16'(near_zero - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	// Called at a falling edge. Presents one request, waits for the rising
	// edge that takes it, records it, then leaves a random gap. valid stays
	// high when there is no gap so back-to-back requests need no toggle.
	task automatic issue_request(cst_op_t op, logic [CST_ID_W-1:0] id,
			logic signed [CST_CNT_W-1:0] init);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.sem_id <= id;
		req_ch.init_value <= init;
		do @(posedge clk); while (!req_ch.ready);
		sem_table.note_request(op, id, init);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending and hold off until every owed response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sem_table.pending() != 0) @(negedge clk);
	endtask

	// Response side: sample at the rising edge, move ready at the falling edge.
	initial begin : response_side
		int stall_left;
		sem_reply_t got;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.status = cst_status_t'(rsp_ch.status);
				got.new_id = rsp_ch.new_id;
				got.must_block = rsp_ch.must_block;
				got.wake_one = rsp_ch.wake_one;
				got.count_after = rsp_ch.count_after;
				sem_table.check_reply(got);
			end
			@(negedge clk);
			if (quiet) begin
				rsp_ch.ready <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Watchdog: a stretch with no handshake on either channel means a hang.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : request_side
		int roll;
		int create_pct;
		int destroy_pct;

		req_ch.valid = 1'b0;
		req_ch.op = OP_CREATE;
		req_ch.sem_id = '0;
		req_ch.init_value = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: ids come out 0, 1, 2, ... from a fresh counter.
		issue_request(OP_CREATE, 16'd0, 16'sd0);        // id 0 at zero
		issue_request(OP_WAIT, 16'd0, 16'sd0);          // drops to -1: caller blocks
		issue_request(OP_SIGNAL, 16'd0, 16'sd0);        // back to 0: one waiter wakes
		issue_request(OP_SIGNAL, 16'd0, 16'sd0);        // 1: nobody left to wake
		issue_request(OP_CREATE, 16'hFFFF, COUNT_MAX);  // id 1 at the top
		issue_request(OP_SIGNAL, 16'd1, 16'sd0);        // holds at the top
		issue_request(OP_CREATE, 16'd0, COUNT_MIN);     // id 2 at the bottom
		issue_request(OP_WAIT, 16'd2, COUNT_MAX);       // holds at the bottom, blocks
		issue_request(OP_SIGNAL, 16'd2, 16'sd0);        // still negative: wakes
		issue_request(OP_DESTROY, 16'd1, 16'sh7FFF);    // reports the count it held
		issue_request(OP_WAIT, 16'd1, 16'sd0);          // id just freed: not found
		issue_request(OP_SIGNAL, 16'hFFFF, COUNT_MIN);  // never issued: not found
		issue_request(OP_DESTROY, 16'h5555, 16'sd0);    // never issued: not found
		// fill the table, then one create too many
		while (sem_table.live_count() < ENTRIES) issue_request(OP_CREATE, 16'd0, random_init());
		issue_request(OP_CREATE, 16'hAAAA, 16'sd7);

		// Pause the sender until the pipe is empty once.
		wait_drained();

		// Random: mostly operations on live ids. Blocks of 100 alternate between
		// filling and draining the table so both the full and empty edges are
		// crossed, and every 200 requests end with a stretch without gaps.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			quiet = ((n % 200) >= 170);
			create_pct = ((n / 100) % 2 == 0) ? 45 : 15;
			destroy_pct = ((n / 100) % 2 == 0) ? 15 : 40;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// noise: any operation on any id, nearly always unknown
				issue_request(cst_op_t'($urandom_range(0, 3)), 16'($urandom), random_init());
			end else if (sem_table.live_count() == 0 || roll < 8 + create_pct) begin
				issue_request(OP_CREATE, 16'($urandom), random_init());
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < destroy_pct)
					issue_request(OP_DESTROY, sem_table.any_live_tag(), random_init());
				else if (roll < destroy_pct + (100 - destroy_pct) / 2)
					issue_request(OP_WAIT, sem_table.any_live_tag(), random_init());
				else
					issue_request(OP_SIGNAL, sem_table.any_live_tag(), random_init());
			end
		end

		for (int n = 0; n < 60; n++) begin
			if (sem_table.live_count() == 0 || $urandom_range(0, 2) == 0)
				issue_request(OP_CREATE, 16'($urandom), random_init());
			else
				issue_request(cst_op_t'($urandom_range(1, 3)), sem_table.any_live_tag(),
					random_init());
		end

		// Let every owed response arrive, then allow a few more cycles for
		// anything spurious to show up.
		wait_drained();
		repeat (20) @(posedge clk);
		if (sem_table.mismatches == 0 && sem_table.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/cst_pkg.sv
sv/cst_intf.sv
sv/cst_ctrl.sv
sv/cst_dp.sv
sv/counting_semaphore_table_unit.sv
test/counting_semaphore_table_unit_tb.sv
